FILE: sv/pedm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pedm_pkg;

    // Delay line defaults
    localparam int MAX_DELAY_DEFAULT = 131072;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WET_PERCENT    = 2'd0,
        REG_EIGHT_BIT_MODE = 2'd1,
        REG_DELAY_LENGTH   = 2'd2,
        REG_UNUSED         = 2'd3
    } cfg_reg_t;

    localparam logic [6:0]  WET_RESET    = 7'd50;
    localparam logic [6:0]  WET_FULL     = 7'd100;
    localparam logic [17:0] DELAY_RESET  = 18'd44100;

    // Sample path widths
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 22;   // |sample| * percent < 2^22
    localparam int MIX_W    = 18;   // signed sum of two scaled terms

    // Divide by 100: floor(n / 100) == (n * RECIP_MUL) >> RECIP_SHIFT, exact for n < 2^22
    localparam int          RECIP_SHIFT = 29;
    localparam int          RECIP_W     = 23;
    localparam logic [22:0] RECIP_MUL   = 23'd5368710;
    localparam int          RPROD_W     = MAG_W + RECIP_W;

    // Saturation limits
    localparam logic signed [MIX_W-1:0] S16_MAX = 18'sd32767;
    localparam logic signed [MIX_W-1:0] S16_MIN = -18'sd32768;
    localparam logic signed [MIX_W-1:0] S8_MAX  = 18'sd127;
    localparam logic signed [MIX_W-1:0] S8_MIN  = -18'sd128;
    localparam logic [7:0]              OFFSET8 = 8'h80;

    // Stages between accept and delivery, output register included
    localparam int PIPE_DEPTH = 4;

endpackage

`default_nettype wire

FILE: sv/pcm_echo_delay_mixer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// PCM echo: delay line with a wet/dry mix.
// Input channel (in_valid/in_ready) carries one interleaved sample word plus a
// block_end mark; output channel (out_valid/out_ready) returns one mixed word per
// input word, in order, with block_end copied through.
// Configuration: cfg_write/cfg_index/cfg_data; the user writes them only while the block is idle (unchecked).
//   index 0 wet_percent (0..100, above 100 acts as 100), index 1 eight_bit_mode,
//   index 2 delay_length (0 acts as 1, above the memory depth acts as the depth).
// Throughput: one word per cycle unless the output stalls. The delay line is a
// single-port read-first memory; each word does its one read and one write in the
// same cycle, so the memory port sets that rate and no forwarding is needed.
// Path: an accepted word passes the memory read, two multiplies, and mix and
// saturate into the output register.
// A stall on the output holds the output register; the stages behind it keep
// filling, so up to four words sit in flight before in_ready drops.
// Reset clears the ring position, the fill count and all valid flags and loads
// the register defaults. Memory entries at or beyond the fill count read as
// silence, so no clearing pass runs and the block takes words right after reset.
module pcm_echo_delay_mixer_top #(
    parameter int MAX_DELAY_SAMPLES = pedm_pkg::MAX_DELAY_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [pedm_pkg::SAMPLE_W-1:0]    sample_in,
    input  wire logic                             block_end,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [pedm_pkg::SAMPLE_W-1:0]         sample_out,
    output logic                                  block_end_out,
    input  wire logic                             cfg_write,
    input  wire logic [pedm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pedm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = (MAX_DELAY_SAMPLES > 1) ? $clog2(MAX_DELAY_SAMPLES) : 1;
    localparam int LEN_W  = $clog2(MAX_DELAY_SAMPLES + 1);
    localparam int SW     = pedm_pkg::SAMPLE_W;
    localparam int MW     = pedm_pkg::MAG_W;
    localparam int XW     = pedm_pkg::MIX_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [6:0]  wet_percent_reg;
    logic        eight_bit_mode_reg;
    logic [17:0] delay_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wet_percent_reg    <= pedm_pkg::WET_RESET;
            eight_bit_mode_reg <= 1'b0;
            delay_length_reg   <= pedm_pkg::DELAY_RESET;
        end
        else if (cfg_write)
        begin
            unique case (pedm_pkg::cfg_reg_t'(cfg_index))
                pedm_pkg::REG_WET_PERCENT:    wet_percent_reg    <= cfg_data[6:0];
                pedm_pkg::REG_EIGHT_BIT_MODE: eight_bit_mode_reg <= cfg_data[0];
                pedm_pkg::REG_DELAY_LENGTH:   delay_length_reg   <= cfg_data[17:0];
                default:                      ;
            endcase
        end
    end

    // Effective mix shares
    logic [6:0] wet_share;
    logic [6:0] dry_share;

    always_comb
    begin
        wet_share = (wet_percent_reg > pedm_pkg::WET_FULL) ? pedm_pkg::WET_FULL
                                                           : wet_percent_reg;
        dry_share = pedm_pkg::WET_FULL - wet_share;
    end

    // Effective delay length
    logic [31:0]      dl_ext;
    logic [LEN_W-1:0] active_len;

    always_comb
    begin
        dl_ext = 32'(delay_length_reg);
        priority if (dl_ext == 32'd0)
            active_len = LEN_W'(1);
        else if (dl_ext > 32'(MAX_DELAY_SAMPLES))
            active_len = LEN_W'(MAX_DELAY_SAMPLES);
        else
            active_len = LEN_W'(dl_ext);
    end

    // ------------------------------------------------------------------
    // Handshake: each stage loads when it is empty or the one after it moves
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic rdy_out, rdy3, rdy2, rdy1;
    logic in_fire;

    assign rdy_out  = !out_valid_reg || out_ready;
    assign rdy3     = !s3_valid_reg || rdy_out;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign in_ready = rdy1;
    assign in_fire  = in_valid && rdy1;

    logic load2, load3, load_out;
    assign load2    = s1_valid_reg && rdy2;
    assign load3    = s2_valid_reg && rdy3;
    assign load_out = s3_valid_reg && rdy_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= in_valid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy_out)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Ring position and fill count
    // Writes land at 0, 1, 2, ... and restart at 0, so the written entries are
    // always a prefix of the memory; fill_reg is its length.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] cur_pos;
    logic [LEN_W-1:0]  cur_ext;
    logic [LEN_W-1:0]  step_pos;
    logic              cur_written;

    always_comb
    begin
        // wrap first when the length was lowered below the position
        cur_pos     = (LEN_W'(pos_reg) >= active_len) ? '0 : pos_reg;
        cur_ext     = LEN_W'(cur_pos);
        step_pos    = cur_ext + LEN_W'(1);
        pos_next    = (step_pos >= active_len) ? '0 : ADDR_W'(step_pos);
        fill_next   = (step_pos > fill_reg) ? step_pos : fill_reg;
        cur_written = cur_ext < fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else if (in_fire)
        begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
        end
    end

    // ------------------------------------------------------------------
    // Normalize the incoming sample
    // ------------------------------------------------------------------
    logic signed [SW-1:0] x_norm;

    always_comb
    begin
        if (eight_bit_mode_reg)
            x_norm = {{8{~sample_in[7]}}, ~sample_in[7], sample_in[6:0]};
        else
            x_norm = sample_in;
    end

    // ------------------------------------------------------------------
    // Delay memory: read-first, one read and one write at the same entry
    // ------------------------------------------------------------------
    logic [SW-1:0] delay_mem [MAX_DELAY_SAMPLES];
    logic [SW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_data_reg        <= delay_mem[cur_pos];
            delay_mem[cur_pos] <= x_norm;
        end
    end

    // Stage 1 payload
    logic signed [SW-1:0] s1_x_reg;
    logic                 s1_hit_reg;
    logic                 s1_end_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_x_reg   <= x_norm;
            s1_hit_reg <= cur_written;
            s1_end_reg <= block_end;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitudes times shares
    // ------------------------------------------------------------------
    logic signed [SW-1:0] delayed;
    logic [SW:0]          x_wide, d_wide;
    logic [SW-1:0]        x_mag, d_mag;
    logic [MW:0]          dry_prod, wet_prod;

    always_comb
    begin
        // an entry never written holds silence
        delayed  = s1_hit_reg ? rd_data_reg : '0;
        x_wide   = {s1_x_reg[SW-1], s1_x_reg};
        d_wide   = {delayed[SW-1], delayed};
        x_mag    = s1_x_reg[SW-1] ? SW'(-x_wide) : SW'(x_wide);
        d_mag    = delayed[SW-1]  ? SW'(-d_wide) : SW'(d_wide);
        dry_prod = (MW+1)'(x_mag) * (MW+1)'(dry_share);
        wet_prod = (MW+1)'(d_mag) * (MW+1)'(wet_share);
    end

    logic [MW-1:0] s2_dry_mag_reg, s2_wet_mag_reg;
    logic          s2_dry_neg_reg, s2_wet_neg_reg;
    logic          s2_end_reg;

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            s2_dry_mag_reg <= dry_prod[MW-1:0];
            s2_wet_mag_reg <= wet_prod[MW-1:0];
            s2_dry_neg_reg <= s1_x_reg[SW-1];
            s2_wet_neg_reg <= delayed[SW-1];
            s2_end_reg     <= s1_end_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide magnitudes by 100 through the reciprocal
    // ------------------------------------------------------------------
    logic [pedm_pkg::RPROD_W-1:0] dry_recip, wet_recip;

    always_comb
    begin
        dry_recip = pedm_pkg::RPROD_W'(s2_dry_mag_reg) * pedm_pkg::RPROD_W'(pedm_pkg::RECIP_MUL);
        wet_recip = pedm_pkg::RPROD_W'(s2_wet_mag_reg) * pedm_pkg::RPROD_W'(pedm_pkg::RECIP_MUL);
    end

    logic [SW-1:0] s3_dry_q_reg, s3_wet_q_reg;
    logic          s3_dry_neg_reg, s3_wet_neg_reg;
    logic          s3_end_reg;

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            s3_dry_q_reg   <= dry_recip[pedm_pkg::RECIP_SHIFT +: SW];
            s3_wet_q_reg   <= wet_recip[pedm_pkg::RECIP_SHIFT +: SW];
            s3_dry_neg_reg <= s2_dry_neg_reg;
            s3_wet_neg_reg <= s2_wet_neg_reg;
            s3_end_reg     <= s2_end_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: restore signs, sum, saturate, encode
    // ------------------------------------------------------------------
    logic signed [XW-1:0] dry_term, wet_term, mix_sum, mix_sat;
    logic [SW-1:0]        code_next;

    always_comb
    begin
        // truncation toward zero: negate the quotient of the magnitude
        dry_term = s3_dry_neg_reg ? -$signed(XW'(s3_dry_q_reg)) : $signed(XW'(s3_dry_q_reg));
        wet_term = s3_wet_neg_reg ? -$signed(XW'(s3_wet_q_reg)) : $signed(XW'(s3_wet_q_reg));
        mix_sum  = dry_term + wet_term;
        if (eight_bit_mode_reg)
        begin
            priority if (mix_sum > pedm_pkg::S8_MAX)
                mix_sat = pedm_pkg::S8_MAX;
            else if (mix_sum < pedm_pkg::S8_MIN)
                mix_sat = pedm_pkg::S8_MIN;
            else
                mix_sat = mix_sum;
            code_next = {8'h00, mix_sat[7:0] ^ pedm_pkg::OFFSET8};
        end
        else
        begin
            priority if (mix_sum > pedm_pkg::S16_MAX)
                mix_sat = pedm_pkg::S16_MAX;
            else if (mix_sum < pedm_pkg::S16_MIN)
                mix_sat = pedm_pkg::S16_MIN;
            else
                mix_sat = mix_sum;
            code_next = mix_sat[SW-1:0];
        end
    end

    logic [SW-1:0] sample_out_reg;
    logic          block_end_out_reg;

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            sample_out_reg    <= code_next;
            block_end_out_reg <= s3_end_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign block_end_out = block_end_out_reg;

endmodule

`default_nettype wire

FILE: sv/pedm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pedm_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [pedm_pkg::SAMPLE_W-1:0]  sample_out,
    input wire logic                           block_end_out
);

    // Count words accepted but not yet delivered
    logic [2:0] pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 3'((in_valid && in_ready) ? 1 : 0)
                                       - 3'((out_valid && out_ready) ? 1 : 0);
    end

    // Drop no result: an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output register");

    // Invent no result
    a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("result offered with no word in flight");

    // Hold no more words than the pipeline has stages
    a_pipe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(pedm_pkg::PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    // Hold the offered word while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out)
                                    && $stable(block_end_out))
        else $error("output word changed while stalled");

endmodule

bind pcm_echo_delay_mixer_top pedm_checker u_pedm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_out    (sample_out),
    .block_end_out (block_end_out)
);

`default_nettype wire
